// ===== rtl/core/lilw_pkg.sv =====
// Shared constants, types and codes of the lane index and width lookup.
package lilw_pkg;

  localparam int MAX_LINES  = 16;
  localparam int COORD_BITS = 12;
  localparam int LINE_IDX_W = $clog2(MAX_LINES);
  localparam int KIND_W     = 8;
  localparam int RC_W       = 4;
  localparam int LANE_W     = 5;
  localparam int LKIND_W    = 9;
  localparam int FRAC_W     = 8;
  localparam int PT_W       = COORD_BITS + 1;
  localparam int NUM_W      = 2 * COORD_BITS + 11;
  localparam int DIV_W      = COORD_BITS;
  localparam int XQ_W       = NUM_W + 1;
  localparam int CHAIN_LEN  = NUM_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROAD_COUNT = 2'd0,
    CFG_ROI_LEFT   = 2'd1,
    CFG_ROI_TOP    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_WIDTH,
    ST_WWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [KIND_W-1:0]     kind;
  } line_t;

  typedef struct packed {
    logic                  is_width;
    logic                  neg;
    logic [LINE_IDX_W-1:0] idx;
    logic [COORD_BITS-1:0] tx;
    logic [KIND_W-1:0]     kind;
  } div_tag_t;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DIV_W-1:0] dvs;
    div_tag_t         tag;
  } div_stage_t;

endpackage

// ===== rtl/core/lilw_req_if.sv =====
// Request channel: one load or query item with valid/ready handshake.
interface lilw_req_if;
  import lilw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [3:0]            line_index;
  logic [COORD_BITS-1:0] top_x;
  logic [COORD_BITS-1:0] top_y;
  logic [COORD_BITS-1:0] bottom_x;
  logic [COORD_BITS-1:0] bottom_y;
  logic [KIND_W-1:0]     lane_kind_in;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;

  modport source (output valid, mode, line_index, top_x, top_y, bottom_x, bottom_y,
                  lane_kind_in, point_x, point_y, input ready);
  modport sink (input valid, mode, line_index, top_x, top_y, bottom_x, bottom_y,
                lane_kind_in, point_x, point_y, output ready);
endinterface

// ===== rtl/core/lilw_rsp_if.sv =====
// Response channel: lane number, lane width and lane kind of one query.
interface lilw_rsp_if;
  import lilw_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [LANE_W-1:0] lane_number;
  logic [COORD_BITS-1:0]    lane_width;
  logic signed [LKIND_W-1:0] lane_kind;

  modport source (output valid, lane_number, lane_width, lane_kind, input ready);
  modport sink (input valid, lane_number, lane_width, lane_kind, output ready);
endinterface

// ===== rtl/core/lane_index_and_width_lookup.sv =====
// Lane index and lane width lookup: top level with sequencer and line table.
//
// Channels: req carries load items (mode 0, write one line of the table) and
// query items (mode 1, a point). rsp carries one result per query: lane
// number, average lane width at the point row, and kind of the found lane.
// Loads give no result. Registers road_count, roi_left and roi_top are
// written through cfg_we / cfg_index / cfg_data. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A load is written into the line table when it is accepted. A query issues
// lines 0..N (N the effective road count) into a row of CHAIN_LEN division
// cells, one line per cycle, then divides the lane span by N through the
// same row, one quotient bit per cell. One query is in work at a time; req
// is ready again once the result sits in the output register, which holds
// it while rsp.ready is low. Reset empties the cell row, drops any pending
// result and sets road_count to 1 and the offsets to 0; the line table is
// not cleared and must be loaded before it is queried.
module lane_index_and_width_lookup
  import lilw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lilw_req_if.sink              req,
  lilw_rsp_if.source            rsp
);

  line_t                 line_table [MAX_LINES];
  logic [RC_W-1:0]       road_count;
  logic [COORD_BITS-1:0] roi_left;
  logic [COORD_BITS-1:0] roi_top;

  state_t st, st_next;
  logic [LINE_IDX_W-1:0] cnt;
  logic [LINE_IDX_W-1:0] rc_q;
  logic [LINE_IDX_W-1:0] rc_eff;
  logic [PT_W-1:0]       px_q;
  logic [PT_W-1:0]       py_q;
  logic                  found;
  logic [LANE_W-1:0]     lane_q;
  logic [LKIND_W-1:0]    kind_q;
  logic [KIND_W-1:0]     prev_kind;
  logic signed [XQ_W-1:0] x0;
  logic [NUM_W-1:0]      diff_q;
  logic [COORD_BITS-1:0] width_q;

  logic req_fire;
  logic rsp_free;

  line_t                    ln;
  logic signed [COORD_BITS:0]   dx, dy, dx_raw, dy_raw;
  logic signed [COORD_BITS+1:0] pdy;
  logic signed [2*COORD_BITS+2:0] prod;
  logic [2*COORD_BITS+2:0]  pmag;
  logic [COORD_BITS:0]      dymag;
  div_stage_t               din, dout;

  logic [XQ_W-1:0]        qe, qs;
  logic signed [XQ_W-1:0] xq;
  logic                   hit;
  logic signed [XQ_W-1:0] span;
  logic [XQ_W-1:0]        span_abs;
  logic [NUM_W-FRAC_W:0]  wround;
  logic [COORD_BITS-1:0]  width_n;
  logic                   line_out, width_out, last_line;

  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;
  assign req.ready = (st == ST_IDLE);

  always_comb begin
    if (road_count == '0) begin
      rc_eff = LINE_IDX_W'(1);
    end else if (32'(road_count) > MAX_LINES - 1) begin
      rc_eff = LINE_IDX_W'(MAX_LINES - 1);
    end else begin
      rc_eff = LINE_IDX_W'(road_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      road_count <= RC_W'(1);
      roi_left   <= '0;
      roi_top    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROAD_COUNT: road_count <= cfg_data[RC_W-1:0];
        CFG_ROI_LEFT:   roi_left   <= cfg_data[COORD_BITS-1:0];
        CFG_ROI_TOP:    roi_top    <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.mode == MODE_LOAD && 32'(req.line_index) < MAX_LINES) begin
      line_table[req.line_index[LINE_IDX_W-1:0]] <= '{
        tx: req.top_x, ty: req.top_y, bx: req.bottom_x, by: req.bottom_y,
        kind: req.lane_kind_in};
    end
  end

  // Line operand setup: offset from the top point times the slope numerator.
  always_comb begin
    ln     = line_table[cnt];
    dx_raw = $signed({1'b0, ln.bx}) - $signed({1'b0, ln.tx});
    dy_raw = $signed({1'b0, ln.by}) - $signed({1'b0, ln.ty});
    dx     = (dx_raw == '0) ? (COORD_BITS+1)'(1) : dx_raw;
    dy     = (dy_raw == '0) ? (COORD_BITS+1)'(1) : dy_raw;
    pdy    = $signed({1'b0, py_q}) - $signed({2'b0, ln.ty});
    prod   = dx * pdy;
    pmag   = prod[2*COORD_BITS+2] ? (2*COORD_BITS+3)'(-prod) : prod;
    dymag  = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

    din = '0;
    if (st == ST_ISSUE) begin
      din.valid        = 1'b1;
      din.nq           = NUM_W'({pmag[2*COORD_BITS:0], {FRAC_W{1'b0}}});
      din.dvs          = dymag[DIV_W-1:0];
      din.tag.neg      = prod[2*COORD_BITS+2] ^ dy[COORD_BITS];
      din.tag.idx      = cnt;
      din.tag.tx       = ln.tx;
      din.tag.kind     = ln.kind;
    end else if (st == ST_WIDTH) begin
      din.valid        = 1'b1;
      din.nq           = diff_q;
      din.dvs          = DIV_W'(rc_q);
      din.tag.is_width = 1'b1;
    end
  end

  lilw_div_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Floor division result back to line X, compare, and width rounding.
  always_comb begin
    qe        = XQ_W'(dout.nq);
    qs        = dout.tag.neg ? (-(qe + XQ_W'(|dout.rem))) : qe;
    xq        = $signed(XQ_W'({dout.tag.tx, 1'b1, {(FRAC_W-1){1'b0}}})) + $signed(qs);
    if (px_q == '0) begin
      hit = xq > -$signed(XQ_W'(1 << FRAC_W));
    end else begin
      hit = xq >= $signed(XQ_W'({px_q, {FRAC_W{1'b0}}}));
    end
    span      = xq - ((dout.tag.idx == '0) ? xq : x0);
    span_abs  = span[XQ_W-1] ? XQ_W'(-span) : span;
    line_out  = dout.valid && !dout.tag.is_width;
    width_out = dout.valid && dout.tag.is_width;
    last_line = line_out && (dout.tag.idx == rc_q);
    wround    = (NUM_W-FRAC_W+1)'((NUM_W+1)'(dout.nq) + (NUM_W+1)'(1 << (FRAC_W-1))
                >> FRAC_W);
    if (dout.nq < NUM_W'(1 << FRAC_W)) begin
      width_n = COORD_BITS'(1);
    end else if (wround > (NUM_W-FRAC_W+1)'({COORD_BITS{1'b1}})) begin
      width_n = '1;
    end else begin
      width_n = wround[COORD_BITS-1:0];
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (req_fire && req.mode == MODE_QUERY) st_next = ST_ISSUE;
      ST_ISSUE: if (cnt == rc_q) st_next = ST_WAIT;
      ST_WAIT:  if (last_line) st_next = ST_WIDTH;
      ST_WIDTH: st_next = ST_WWAIT;
      ST_WWAIT: if (width_out) st_next = ST_DONE;
      ST_DONE:  if (rsp_free) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      cnt       <= '0;
      found     <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_ISSUE) begin
        cnt <= cnt + LINE_IDX_W'(1);
      end else if (st == ST_IDLE) begin
        cnt <= '0;
      end
      if (req_fire) begin
        found <= 1'b0;
      end else if (line_out && hit) begin
        found <= 1'b1;
      end
      if (st == ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rc_q   <= rc_eff;
      px_q   <= PT_W'(req.point_x) + PT_W'(roi_left);
      py_q   <= PT_W'(req.point_y) + PT_W'(roi_top);
      lane_q <= '1;
      kind_q <= '1;
    end else if (line_out && hit && !found) begin
      lane_q <= LANE_W'(dout.tag.idx) - LANE_W'(1);
      kind_q <= (dout.tag.idx == '0) ? '1 : {1'b0, prev_kind};
    end
    if (line_out) begin
      prev_kind <= dout.tag.kind;
      if (dout.tag.idx == '0) begin
        x0 <= xq;
      end
    end
    if (last_line) begin
      diff_q <= span_abs[NUM_W-1:0];
    end
    if (width_out) begin
      width_q <= width_n;
    end
    if (st == ST_DONE && rsp_free) begin
      rsp.lane_number <= lane_q;
      rsp.lane_kind   <= kind_q;
      rsp.lane_width  <= width_q;
    end
  end

endmodule

// ===== rtl/core/lilw_div_cell.sv =====
// One restoring division cell: settles one quotient bit and hands on.
module lilw_div_cell
  import lilw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t din,
  output div_stage_t dout
);

  logic [DIV_W:0] trial;
  logic           ge;
  logic [DIV_W:0] diff;

  always_comb begin
    trial = {din.rem, din.nq[NUM_W-1]};
    ge    = trial >= {1'b0, din.dvs};
    diff  = trial - {1'b0, din.dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dout.nq  <= {din.nq[NUM_W-2:0], ge};
    dout.dvs <= din.dvs;
    dout.tag <= din.tag;
  end

endmodule

// ===== rtl/core/lilw_div_chain.sv =====
// Row of division cells, one quotient bit per cell, new operand every cycle.
module lilw_div_chain
  import lilw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t din,
  output div_stage_t dout
);

  div_stage_t stage [CHAIN_LEN+1];

  assign stage[0] = din;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    lilw_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[CHAIN_LEN];

endmodule

// ===== rtl/core/lilw_checker.sv =====
// Port checks of the lane lookup, bound to the top level.
module lilw_checker
  import lilw_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  req_mode,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [LANE_W-1:0]     lane_number,
  input logic [COORD_BITS-1:0] lane_width,
  input logic [LKIND_W-1:0]    lane_kind
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(lane_number) &&
    $stable(lane_width) && $stable(lane_kind))
    else $error("response dropped or changed while stalled");

  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> lane_width != '0)
    else $error("lane width below one");

  a_kind_matches_lane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((lane_number == '1) == (lane_kind == '1)) &&
    (lane_number == '1 || !lane_kind[LKIND_W-1]))
    else $error("lane kind does not match lane number");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> lane_number != LANE_W'(MAX_LINES - 1))
    else $error("lane number beyond last lane");

  a_load_no_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_mode == MODE_LOAD && !rsp_valid |=> !rsp_valid)
    else $error("response raised after a load");

endmodule

bind lane_index_and_width_lookup lilw_checker u_lilw_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_mode    (req.mode),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .lane_number (rsp.lane_number),
  .lane_width  (rsp.lane_width),
  .lane_kind   (rsp.lane_kind)
);
